/* src/may_cache_age_update_defines.svh */
// assertion macros shared by the age update block
`ifndef MAY_CACHE_AGE_UPDATE_DEFINES_SVH
`define MAY_CACHE_AGE_UPDATE_DEFINES_SVH

// checked at every clock edge outside reset
`define MCA_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every clock edge, reset included
`define MCA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/mca_pkg.sv */
// types, codes and the age join for the may-analysis age vector
`timescale 1ns / 1ps

package mca_pkg;

  localparam int AGE_W      = 5;
  localparam int SET_W      = 10;
  localparam int BLK_W      = 4;
  localparam int CMD_W      = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = SET_W;

  localparam logic [AGE_W-1:0] BOTTOM_AGE  = 5'd31;
  localparam logic [AGE_W-1:0] ASSOC_RESET = 5'd4;

  localparam logic [CMD_W-1:0] CMD_NONE     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FETCH    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PREFETCH = 3'd2;
  localparam logic [CMD_W-1:0] CMD_WRITE    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_JOIN     = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ     = 3'd5;
  localparam logic [CMD_W-1:0] CMD_BOTTOM   = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_ASSOC = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SET   = 1'b1;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [BLK_W-1:0] block_index;
    logic [SET_W-1:0] access_set;
    logic [AGE_W-1:0] age_in;
  } mca_item_t;

  // may join: the younger age wins, bottom yields the other side
  function automatic logic [AGE_W-1:0] join_age(input logic [AGE_W-1:0] x,
                                                input logic [AGE_W-1:0] y);
    logic [AGE_W-1:0] r;
    if (x == BOTTOM_AGE) begin
      r = y;
    end else if (y == BOTTOM_AGE) begin
      r = x;
    end else begin
      r = (x < y) ? x : y;
    end
    return r;
  endfunction

endpackage

/* src/mca_update.sv */
// next-state logic of the age vector for one word
`timescale 1ns / 1ps

module mca_update import mca_pkg::*; #(
  parameter int BLOCKS = 16
) (
  input  logic [BLOCKS-1:0][AGE_W-1:0] ages,
  input  mca_item_t                    item,
  input  logic [AGE_W-1:0]             assoc,
  input  logic [SET_W-1:0]             analyzed_set,
  output logic [BLOCKS-1:0][AGE_W-1:0] ages_next,
  output logic [AGE_W-1:0]             age_out,
  output logic                         is_bottom
);

  logic                         in_range;
  logic                         do_access;
  logic [AGE_W-1:0]             ref_age;
  logic [BLOCKS-1:0]            hit;
  logic [BLOCKS-1:0][AGE_W-1:0] fetched;

  assign in_range  = int'(item.block_index) < BLOCKS;
  assign do_access = in_range && (ages[0] != BOTTOM_AGE) &&
                     (item.access_set == analyzed_set);

  always_comb begin
    ref_age = BOTTOM_AGE;
    for (int i = 0; i < BLOCKS; i++) begin
      hit[i] = int'(item.block_index) == i;
      if (hit[i]) begin
        ref_age = ages[i];
      end
    end
  end

  // lru aging, saturating at the associativity
  always_comb begin
    for (int i = 0; i < BLOCKS; i++) begin
      if (hit[i]) begin
        fetched[i] = '0;
      end else if (ages[i] != BOTTOM_AGE && ages[i] <= ref_age && ages[i] < assoc) begin
        fetched[i] = ages[i] + AGE_W'(1);
      end else begin
        fetched[i] = ages[i];
      end
    end
  end

  always_comb begin
    ages_next = ages;
    case (item.command)
      CMD_FETCH: begin
        if (do_access) begin
          ages_next = fetched;
        end
      end
      CMD_PREFETCH: begin
        if (do_access) begin
          for (int i = 0; i < BLOCKS; i++) begin
            ages_next[i] = join_age(fetched[i], ages[i]);
          end
        end
      end
      CMD_WRITE: begin
        for (int i = 0; i < BLOCKS; i++) begin
          if (hit[i]) begin
            ages_next[i] = item.age_in;
          end
        end
      end
      CMD_JOIN: begin
        for (int i = 0; i < BLOCKS; i++) begin
          if (hit[i]) begin
            ages_next[i] = join_age(ages[i], item.age_in);
          end
        end
      end
      CMD_BOTTOM: begin
        for (int i = 0; i < BLOCKS; i++) begin
          ages_next[i] = BOTTOM_AGE;
        end
      end
      CMD_NONE, CMD_READ: begin
        ages_next = ages;
      end
      default: begin
        ages_next = ages;
      end
    endcase
  end

  always_comb begin
    age_out = BOTTOM_AGE;
    for (int i = 0; i < BLOCKS; i++) begin
      if (hit[i]) begin
        age_out = ages_next[i];
      end
    end
  end

  assign is_bottom = ages_next[0] == BOTTOM_AGE;

endmodule

/* src/may_cache_age_update.sv */
// may-analysis lru age vector of one cache set
//
// Input channel (in_valid/in_ready) takes one word per cycle unless stalled:
// a command, the block addressed, the access's cache set and an age operand.
// Output channel (out_valid/out_ready) returns one word per input word:
// the age of the addressed block after the command and the bottom flag.
// A word is first held in the input register; the update of the age
// vector and the result register load happen together when the word
// advances out of it, which waits while the result register is full and
// not taken. Throughput is one word per cycle while the receiver does
// not stall, set by the single update stage over the register vector.
// When the receiver stalls, the result register holds, the input register
// fills, and then in_ready drops until the result is taken.
// Configuration is a plain write port: index 0 associativity, index 1 the
// analysed set; write only while no word is in flight.
// Synchronous reset puts every age to zero (top state), associativity
// to four, analysed set to zero, and empties both registers.
`timescale 1ns / 1ps

module may_cache_age_update import mca_pkg::*; #(
  parameter int BLOCKS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CMD_W-1:0]      command,
  input  logic [BLK_W-1:0]      block_index,
  input  logic [SET_W-1:0]      access_set,
  input  logic [AGE_W-1:0]      age_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [AGE_W-1:0]      age_out,
  output logic                  is_bottom
);

  `include "may_cache_age_update_defines.svh"

  logic [AGE_W-1:0]             assoc;
  logic [SET_W-1:0]             analyzed_set;
  logic [BLOCKS-1:0][AGE_W-1:0] ages;
  logic [BLOCKS-1:0][AGE_W-1:0] ages_next;
  mca_item_t                    item;
  logic                         item_valid;
  logic                         advance;
  logic [AGE_W-1:0]             age_out_next;
  logic                         is_bottom_next;

  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      assoc        <= ASSOC_RESET;
      analyzed_set <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ASSOC: assoc        <= cfg_data[AGE_W-1:0];
        CFG_SET:   analyzed_set <= cfg_data;
        default:   ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= '{command: command, block_index: block_index,
                access_set: access_set, age_in: age_in};
    end
  end

  mca_update #(
    .BLOCKS (BLOCKS)
  ) u_update (
    .ages         (ages),
    .item         (item),
    .assoc        (assoc),
    .analyzed_set (analyzed_set),
    .ages_next    (ages_next),
    .age_out      (age_out_next),
    .is_bottom    (is_bottom_next)
  );

  // vector and result move together
  always_ff @(posedge clk) begin
    if (rst) begin
      ages      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        ages      <= ages_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      age_out   <= age_out_next;
      is_bottom <= is_bottom_next;
    end
  end

  `MCA_ASSERT_CLK(a_stall_means_full, !in_ready |-> (item_valid && out_valid && !out_ready),
    "input stalled without a full pipe")
  `MCA_ASSERT_CLK(a_advance_gives_result, advance |=> out_valid,
    "update stage fired but no result followed")
  `MCA_ASSERT_CLK(a_make_bottom_flag,
    (advance && item.command == CMD_BOTTOM) |=> (is_bottom && ages[0] == BOTTOM_AGE),
    "make bottom did not leave a bottom state")
  `MCA_ASSERT_CLK(a_flag_tracks_vector, (advance) |=> (is_bottom == (ages[0] == BOTTOM_AGE)),
    "bottom flag disagrees with the stored vector")
  `MCA_ASSERT_ALWAYS(a_reset_empties, rst |=> (!out_valid && !item_valid),
    "registers not empty after reset")

endmodule

/* tb/may_cache_age_update_test.sv */
// self-checking testbench for the may-analysis lru age vector block
`timescale 1ns / 1ps

module may_cache_age_update_test;
  import mca_pkg::*;

  localparam int BLOCKS = 16;
  localparam logic [CMD_W-1:0] CMD_SPARE = 3'd7;
  localparam int STOP_NS = 8_000_000;
  localparam int PRINT_CAP = 40;

  typedef struct packed {
    logic [AGE_W-1:0] age;
    logic             bottom;
  } age_result_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_ASSOC;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [CMD_W-1:0]      command = CMD_NONE;
  logic [BLK_W-1:0]      block_index = '0;
  logic [SET_W-1:0]      access_set = '0;
  logic [AGE_W-1:0]      age_in = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [AGE_W-1:0]      age_out;
  logic                  is_bottom;

  // own copy of the age vector and configuration
  logic [AGE_W-1:0] model_ages [BLOCKS];
  logic [AGE_W-1:0] model_assoc;
  logic [SET_W-1:0] model_set;
  age_result_t      pending_ages [$];
  int               errors = 0;
  bit               pace = 1'b0;
  int               stall_left = 0;

  may_cache_age_update #(
    .BLOCKS(BLOCKS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .block_index(block_index),
    .access_set(access_set),
    .age_in(age_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .age_out(age_out),
    .is_bottom(is_bottom)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(STOP_NS);
    $display("** may_cache_age_update: FAILED **");
    $finish;
  end

  // younger age wins, bottom gives way to the other side
  function automatic logic [AGE_W-1:0] merge_age(input logic [AGE_W-1:0] a,
                                                 input logic [AGE_W-1:0] b);
    if (a == BOTTOM_AGE) return b;
    if (b == BOTTOM_AGE) return a;
    return (a < b) ? a : b;
  endfunction

  function automatic void age_on_access(input logic [BLK_W-1:0] blk);
    logic [AGE_W-1:0] pivot;
    logic [AGE_W-1:0] v;
    pivot = model_ages[blk];
    for (int i = 0; i < BLOCKS; i++) begin
      v = model_ages[i];
      if (v != BOTTOM_AGE && v <= pivot && v < model_assoc) begin
        model_ages[i] = v + AGE_W'(1);
      end
    end
    model_ages[blk] = '0;
  endfunction

  function automatic age_result_t update_ages(input logic [CMD_W-1:0] cmd,
                                              input logic [BLK_W-1:0] blk,
                                              input logic [SET_W-1:0] acc_set,
                                              input logic [AGE_W-1:0] age);
    logic [AGE_W-1:0] prior [BLOCKS];
    logic             live;
    age_result_t      res;
    live = (acc_set == model_set) && (model_ages[0] != BOTTOM_AGE);
    case (cmd)
      CMD_FETCH: begin
        if (live) age_on_access(blk);
      end
      CMD_PREFETCH: begin
        if (live) begin
          prior = model_ages;
          age_on_access(blk);
          for (int i = 0; i < BLOCKS; i++) begin
            model_ages[i] = merge_age(model_ages[i], prior[i]);
          end
        end
      end
      CMD_WRITE: begin
        model_ages[blk] = age;
      end
      CMD_JOIN: begin
        model_ages[blk] = merge_age(model_ages[blk], age);
      end
      CMD_BOTTOM: begin
        for (int i = 0; i < BLOCKS; i++) model_ages[i] = BOTTOM_AGE;
      end
      default: begin
      end
    endcase
    res.age = model_ages[blk];
    res.bottom = (model_ages[0] == BOTTOM_AGE);
    return res;
  endfunction

  // mostly short gaps, a few long ones, none while pace is off
  function automatic int idle_cycles();
    int r;
    if (!pace) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic logic [AGE_W-1:0] pick_age();
    if ($urandom_range(0, 9) < 7) return AGE_W'($urandom_range(0, model_assoc));
    return AGE_W'($urandom_range(0, 31));
  endfunction

  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [BLK_W-1:0] blk,
                           input logic [SET_W-1:0] acc_set,
                           input logic [AGE_W-1:0] age);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    command     <= cmd;
    block_index <= blk;
    access_set  <= acc_set;
    age_in      <= age;
    do @(posedge clk); while (!in_ready);
    pending_ages.push_back(update_ages(cmd, blk, acc_set, age));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_ages.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ASSOC) model_assoc = data[AGE_W-1:0];
    else model_set = data[SET_W-1:0];
  endtask

  // receiver side: random stalls on out_ready
  always @(posedge clk) begin
    if (stall_left == 0) stall_left = idle_cycles();
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    age_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_ages.size() == 0) begin
        if (errors < PRINT_CAP)
          $display("%0t: result word with nothing expected, age_out %0d is_bottom %0b",
                   $time, age_out, is_bottom);
        errors++;
      end else begin
        want = pending_ages.pop_front();
        if (age_out !== want.age) begin
          if (errors < PRINT_CAP)
            $display("%0t: age_out mismatch, expected %0d, got %0d",
                     $time, want.age, age_out);
          errors++;
        end
        if (is_bottom !== want.bottom) begin
          if (errors < PRINT_CAP)
            $display("%0t: is_bottom mismatch, expected %0b, got %0b",
                     $time, want.bottom, is_bottom);
          errors++;
        end
      end
    end
  end

  task automatic test_reset_state();
    send_word(CMD_READ, 4'd0, 10'd0, 5'd0);
    send_word(CMD_READ, 4'd15, 10'd1023, 5'd31);
  endtask

  task automatic test_fetch_prefetch();
    send_word(CMD_FETCH, 4'd3, 10'd0, 5'd0);
    send_word(CMD_FETCH, 4'd9, 10'd0, 5'd17);
    send_word(CMD_PREFETCH, 4'd15, 10'd0, 5'd0);
    send_word(CMD_READ, 4'd3, 10'd0, 5'd0);
  endtask

  task automatic test_other_set_and_spare();
    send_word(CMD_FETCH, 4'd5, 10'd1023, 5'd0);
    send_word(CMD_PREFETCH, 4'd6, 10'd1, 5'd0);
    send_word(CMD_NONE, 4'd15, 10'd1023, 5'd31);
    send_word(CMD_SPARE, 4'd0, 10'd0, 5'd31);
  endtask

  // ages above the associativity only come from writes and never age further
  task automatic test_high_ages();
    send_word(CMD_WRITE, 4'd2, 10'd1023, 5'd30);
    send_word(CMD_WRITE, 4'd7, 10'd512, 5'd31);
    send_word(CMD_FETCH, 4'd2, 10'd0, 5'd0);
    send_word(CMD_FETCH, 4'd7, 10'd0, 5'd0);
    send_word(CMD_JOIN, 4'd2, 10'd77, 5'd1);
    send_word(CMD_JOIN, 4'd7, 10'd0, 5'd31);
    send_word(CMD_JOIN, 4'd7, 10'd0, 5'd0);
  endtask

  task automatic test_bottom_state();
    send_word(CMD_BOTTOM, 4'd8, 10'd0, 5'd0);
    send_word(CMD_FETCH, 4'd1, 10'd0, 5'd0);
    send_word(CMD_PREFETCH, 4'd1, 10'd0, 5'd0);
    send_word(CMD_JOIN, 4'd4, 10'd300, 5'd3);
    send_word(CMD_WRITE, 4'd0, 10'd1023, 5'd0);
    send_word(CMD_FETCH, 4'd0, 10'd0, 5'd0);
    send_word(CMD_READ, 4'd4, 10'd0, 5'd0);
  endtask

  task automatic test_random_traffic(input logic [AGE_W-1:0] assoc,
                                     input logic [SET_W-1:0] tracked, input int count);
    logic [BLK_W-1:0] blk;
    int               r;
    wait_idle();
    write_config(CFG_ASSOC, CFG_DATA_W'(assoc));
    write_config(CFG_SET, tracked);
    for (int n = 0; n < count; n++) begin
      if (n % 50 == 0) pace = ($urandom_range(0, 3) != 0);
      blk = BLK_W'($urandom_range(0, BLOCKS - 1));
      r = $urandom_range(0, 99);
      if (model_ages[0] == BOTTOM_AGE && $urandom_range(0, 1)) begin
        // climb back out of bottom so that accesses take effect again
        send_word(CMD_WRITE, 4'd0, SET_W'($urandom_range(0, 1023)),
                  AGE_W'($urandom_range(0, model_assoc)));
      end else if (r < 30) begin
        send_word(CMD_FETCH, blk, model_set, AGE_W'($urandom_range(0, 31)));
      end else if (r < 45) begin
        send_word(CMD_PREFETCH, blk, model_set, AGE_W'($urandom_range(0, 31)));
      end else if (r < 57) begin
        send_word(CMD_READ, blk, SET_W'($urandom_range(0, 1023)),
                  AGE_W'($urandom_range(0, 31)));
      end else if (r < 67) begin
        send_word(CMD_WRITE, blk, SET_W'($urandom_range(0, 1023)), pick_age());
      end else if (r < 77) begin
        send_word(CMD_JOIN, blk, SET_W'($urandom_range(0, 1023)), pick_age());
      end else if (r < 80) begin
        send_word(CMD_BOTTOM, blk, SET_W'($urandom_range(0, 1023)),
                  AGE_W'($urandom_range(0, 31)));
      end else if (r < 86) begin
        send_word($urandom_range(0, 1) ? CMD_NONE : CMD_SPARE, blk,
                  SET_W'($urandom_range(0, 1023)), AGE_W'($urandom_range(0, 31)));
      end else begin
        send_word($urandom_range(0, 1) ? CMD_FETCH : CMD_PREFETCH, blk,
                  SET_W'($urandom_range(0, 1023)), AGE_W'($urandom_range(0, 31)));
      end
    end
    pace = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < BLOCKS; i++) model_ages[i] = '0;
    model_assoc = ASSOC_RESET;
    model_set = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_fetch_prefetch();
    test_other_set_and_spare();
    test_high_ages();
    test_bottom_state();

    test_random_traffic(5'd1, 10'd1023, 330);
    test_random_traffic(5'd16, 10'd0, 330);
    test_random_traffic(5'd15, 10'h2aa, 330);
    test_random_traffic(5'd2, 10'h155, 330);
    test_random_traffic(AGE_W'($urandom_range(1, 16)), SET_W'($urandom_range(0, 1023)), 340);
    test_random_traffic(AGE_W'($urandom_range(1, 16)), SET_W'($urandom_range(0, 1023)), 340);

    wait_idle();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("** may_cache_age_update: PASSED **");
    end else begin
      $display("** may_cache_age_update: FAILED **");
    end
    $finish;
  end

endmodule

/* may_cache_age_update.f */
+incdir+src
src/mca_pkg.sv
src/mca_update.sv
src/may_cache_age_update.sv
tb/may_cache_age_update_test.sv
